### rtl/k_way_sorted_merge_top_defines.svh
// assertion macros for the k-way merge block
// used by the checker module only
`ifndef K_WAY_SORTED_MERGE_TOP_DEFINES_SVH
`define K_WAY_SORTED_MERGE_TOP_DEFINES_SVH
`define KWM_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("kwm check failed");
`define KWM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("kwm check failed");
`endif

### rtl/kwm_pkg.sv
// types and codes shared by the k-way merge modules
// no dependencies
package kwm_pkg;
    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_TAKE   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } op_t;
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;
    typedef enum logic [2:0] {
        S_IDLE, S_APPEND, S_READ, S_SCAN, S_DONE
    } state_t;
    typedef struct packed {
        logic [1:0]  operation;
        logic [2:0]  list_index;
        logic [31:0] value;
    } item_t;
    localparam int CFG_LIST_COUNT = 0;
endpackage

### rtl/kwm_ram.sv
// generic single-port-write, single-read ram with registered read
// no dependencies
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/kwm_front.sv
// front part: accepts items into a two-entry queue
// depends on kwm_pkg
module kwm_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  kwm_pkg::item_t in_item,
    output logic           q_valid,
    input  logic           q_ready,
    output kwm_pkg::item_t q_item
);
    import kwm_pkg::*;
    item_t       buf_reg [2];
    logic        wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rp_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            buf_reg[wp_reg] <= in_item;
        end
    end
endmodule

### rtl/kwm_back.sv
// back part: list bookkeeping, store access and head scan
// depends on kwm_pkg and kwm_ram
module kwm_back #(
    parameter int MAX_LISTS       = 8,
    parameter int MAX_LIST_LENGTH = 256
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [3:0]     list_count,
    input  logic           q_valid,
    output logic           q_ready,
    input  kwm_pkg::item_t q_item,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [31:0]    m_merged_value,
    output logic           m_is_last,
    output logic [1:0]     m_status
);
    import kwm_pkg::*;
    localparam int LW = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
    localparam int PW = (MAX_LIST_LENGTH > 1) ? $clog2(MAX_LIST_LENGTH) : 1;
    localparam int CW = $clog2(MAX_LIST_LENGTH + 1);
    localparam int AW = LW + PW;
    localparam int NW = $clog2(MAX_LISTS + 1);

    state_t          state_reg, state_next;
    logic [CW-1:0]   fill_reg [MAX_LISTS];
    logic [CW-1:0]   rpos_reg [MAX_LISTS];
    item_t           cur_reg;
    logic [LW-1:0]   idx_reg, idx_next;
    logic            found_reg;
    logic [LW-1:0]   best_reg;
    logic [31:0]     best_val_reg;
    logic            out_valid_reg;
    logic [31:0]     out_val_reg;
    logic            out_last_reg;
    logic [1:0]      out_st_reg;
    logic [NW-1:0]   n_act;
    logic [MAX_LISTS-1:0] avail;
    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [31:0]     rdata;
    logic [LW-1:0]   ali;
    logic            ali_ok;
    logic            last_idx;
    logic            more_after;

    kwm_ram #(.WIDTH(32), .DEPTH(1 << AW)) u_store (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(cur_reg.value),
        .raddr(raddr), .rdata(rdata)
    );

    always_comb begin
        if (32'(list_count) > 32'(MAX_LISTS)) n_act = NW'(MAX_LISTS);
        else n_act = NW'(list_count);
    end

    always_comb begin
        for (int i = 0; i < MAX_LISTS; i++) begin
            avail[i] = (NW'(i) < n_act) && (rpos_reg[i] < fill_reg[i]);
        end
    end

    assign ali      = LW'(cur_reg.list_index);
    assign ali_ok   = (32'(cur_reg.list_index) < 32'(n_act));
    assign we       = (state_reg == S_APPEND) && ali_ok
                      && (fill_reg[ali] < CW'(MAX_LIST_LENGTH));
    assign waddr    = AW'({ali, PW'(fill_reg[ali])});
    assign raddr    = AW'({idx_reg, PW'(rpos_reg[idx_reg])});
    assign last_idx = (NW'(idx_reg) + 1'b1 >= n_act);
    assign q_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_merged_value = out_val_reg;
    assign m_is_last      = out_last_reg;
    assign m_status       = out_st_reg;

    always_comb begin
        more_after = 1'b0;
        for (int i = 0; i < MAX_LISTS; i++) begin
            if (LW'(i) == best_reg) begin
                if ((NW'(i) < n_act) && (rpos_reg[i] + 1'b1 < fill_reg[i])) more_after = 1'b1;
            end else if (avail[i]) begin
                more_after = 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (q_valid && q_ready) begin
                    case (q_item.operation)
                        OP_APPEND: state_next = S_APPEND;
                        OP_TAKE:   state_next = S_READ;
                        default:   state_next = S_DONE;
                    endcase
                end
            end
            S_APPEND: state_next = S_DONE;
            S_READ:   state_next = (n_act == '0) ? S_DONE : S_SCAN;
            S_SCAN:   state_next = last_idx ? S_DONE : S_READ;
            S_DONE:   state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        idx_next = idx_reg;
        case (state_reg)
            S_IDLE:  idx_next = '0;
            S_SCAN:  idx_next = idx_reg + 1'b1;
            default: idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            for (int i = 0; i < MAX_LISTS; i++) begin
                fill_reg[i] <= '0;
                rpos_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            case (state_reg)
                S_IDLE: begin
                    found_reg <= 1'b0;
                    if (m_valid && m_ready) out_valid_reg <= 1'b0;
                    if (q_valid && q_ready) cur_reg <= q_item;
                end
                S_APPEND: begin
                    out_val_reg  <= '0;
                    out_last_reg <= 1'b0;
                    if (!ali_ok) out_st_reg <= ST_BAD_INDEX;
                    else if (!we) out_st_reg <= ST_FULL;
                    else begin
                        out_st_reg    <= ST_OK;
                        fill_reg[ali] <= fill_reg[ali] + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (avail[idx_reg] && (!found_reg
                        || $signed(rdata) < $signed(best_val_reg))) begin
                        found_reg    <= 1'b1;
                        best_reg     <= idx_reg;
                        best_val_reg <= rdata;
                    end
                end
                S_DONE: begin
                    out_valid_reg <= 1'b1;
                    if (cur_reg.operation == OP_TAKE) begin
                        if (!found_reg) begin
                            out_val_reg  <= '0;
                            out_last_reg <= 1'b0;
                            out_st_reg   <= ST_EMPTY;
                        end else begin
                            out_val_reg        <= best_val_reg;
                            out_last_reg       <= !more_after;
                            out_st_reg         <= ST_OK;
                            rpos_reg[best_reg] <= rpos_reg[best_reg] + 1'b1;
                        end
                    end else if (cur_reg.operation != OP_APPEND) begin
                        out_val_reg  <= '0;
                        out_last_reg <= 1'b0;
                        out_st_reg   <= ST_OK;
                        if (cur_reg.operation == OP_CLEAR) begin
                            for (int i = 0; i < MAX_LISTS; i++) begin
                                fill_reg[i] <= '0;
                                rpos_reg[i] <= '0;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

### rtl/k_way_sorted_merge_top.sv
// k-way merge top level: apb register, front queue, back engine
// depends on kwm_pkg, kwm_front, kwm_back
// A take does one store read and one compare per active list in the back
// engine; the next queued item starts the cycle after the result is taken,
// and a two-entry queue lets new items arrive meanwhile.
// Each list has a power-of-two slot of words in one memory. Register 0 at
// address 0 is list_count (4 bits, reset 8).
module k_way_sorted_merge_top #(
    parameter int MAX_LISTS       = 8,
    parameter int MAX_LIST_LENGTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [2:0]  s_list_index,
    input  logic [31:0] s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_merged_value,
    output logic        m_is_last,
    output logic [1:0]  m_status
);
    import kwm_pkg::*;
    logic [3:0] list_count_reg;
    item_t      in_item, q_item;
    logic       q_valid, q_ready;

    assign pready  = 1'b1;
    assign prdata  = (paddr == 2'(CFG_LIST_COUNT * 4)) ? {28'd0, list_count_reg} : 32'd0;
    assign in_item = '{operation: s_operation, list_index: s_list_index, value: s_value};

    always_ff @(posedge aclk) begin
        if (!aresetn) list_count_reg <= 4'd8;
        else if (psel && penable && pwrite && paddr == 2'(CFG_LIST_COUNT * 4))
            list_count_reg <= pwdata[3:0];
    end

    kwm_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_ready(s_ready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    kwm_back #(.MAX_LISTS(MAX_LISTS), .MAX_LIST_LENGTH(MAX_LIST_LENGTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .list_count(list_count_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_merged_value(m_merged_value),
        .m_is_last(m_is_last), .m_status(m_status)
    );
endmodule

### rtl/kwm_checker.sv
// port-level checks for the k-way merge block
// depends on kwm_pkg and k_way_sorted_merge_top_defines.svh
`include "k_way_sorted_merge_top_defines.svh"
module kwm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_merged_value,
    input logic        m_is_last,
    input logic [1:0]  m_status,
    input logic        pready
);
    import kwm_pkg::*;
    `KWM_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_merged_value))
    `KWM_ASSERT_IMPL(a_last_ok, aclk, aresetn, m_valid && m_is_last, m_status == ST_OK)
    `KWM_ASSERT_IMPL(a_err_zero, aclk, aresetn, m_valid && m_status != ST_OK, m_merged_value == 32'd0)
    `KWM_ASSERT_IMPL(a_pready, aclk, aresetn, 1'b1, pready)
endmodule

bind k_way_sorted_merge_top kwm_checker u_kwm_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_merged_value(m_merged_value), .m_is_last(m_is_last), .m_status(m_status),
    .pready(pready)
);

### sim/kwm_checker.sv
// checker for the k-way merge block: watches both channels, predicts each result
// depends on kwm_pkg; the top passes register writes in through cfg_we and cfg_count
module kwm_scoreboard #(
    parameter int MAX_LISTS       = 8,
    parameter int MAX_LIST_LENGTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_count,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [2:0]  s_list_index,
    input  logic [31:0] s_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_merged_value,
    input  logic        m_is_last,
    input  logic [1:0]  m_status,
    output int          fail_count,
    output int          pending,
    output int          results_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import kwm_pkg::*;

    typedef struct packed {
        logic [31:0] merged;
        logic        last;
        logic [1:0]  status;
    } merge_result_t;

    logic [31:0]   list_mem [MAX_LISTS * MAX_LIST_LENGTH];
    int unsigned   fill [MAX_LISTS];
    int unsigned   rpos [MAX_LISTS];
    logic [3:0]    lists_on;
    merge_result_t merge_q[$];

    function automatic merge_result_t merge_step(logic [1:0] op, logic [2:0] li,
                                                 logic [31:0] v);
        merge_result_t r;
        int unsigned n;
        int best;
        logic signed [31:0] best_v;
        bit more;
        r = '0;
        n = (lists_on > MAX_LISTS) ? MAX_LISTS : lists_on;
        best = -1;
        best_v = 0;
        more = 0;
        case (op)
            OP_APPEND: begin
                if (li >= n) r.status = ST_BAD_INDEX;
                else if (fill[li] >= MAX_LIST_LENGTH) r.status = ST_FULL;
                else begin
                    list_mem[li * MAX_LIST_LENGTH + fill[li]] = v;
                    fill[li]++;
                    r.status = ST_OK;
                end
            end
            OP_TAKE: begin
                for (int i = 0; i < n; i++)
                    if (rpos[i] < fill[i] &&
                        (best < 0 || $signed(list_mem[i * MAX_LIST_LENGTH + rpos[i]]) < best_v)) begin
                        best = i;
                        best_v = list_mem[i * MAX_LIST_LENGTH + rpos[i]];
                    end
                if (best < 0) r.status = ST_EMPTY;
                else begin
                    rpos[best]++;
                    for (int i = 0; i < n; i++) if (rpos[i] < fill[i]) more = 1;
                    r.merged = best_v;
                    r.last = !more;
                    r.status = ST_OK;
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < MAX_LISTS; i++) begin
                    fill[i] = 0;
                    rpos[i] = 0;
                end
                r.status = ST_OK;
            end
            default: r.status = ST_OK;
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        merge_result_t e;
        if (!aresetn) begin
            for (int i = 0; i < MAX_LISTS; i++) begin
                fill[i] = 0;
                rpos[i] = 0;
            end
            lists_on = 4'd8;
            merge_q.delete();
            fail_count = 0;
            results_seen = 0;
        end else begin
            if (cfg_we) lists_on = cfg_count;
            if (m_valid && m_ready) begin
                results_seen++;
                if (merge_q.size() == 0) begin
                    fail_count++;
                    $display("%0t unexpected result value %0d status %0d", $time,
                             $signed(m_merged_value), m_status);
                end else begin
                    e = merge_q.pop_front();
                    if (e.merged !== m_merged_value) begin
                        fail_count++;
                        $display("%0t merged_value expected %0d actual %0d", $time,
                                 $signed(e.merged), $signed(m_merged_value));
                    end
                    if (e.last !== m_is_last) begin
                        fail_count++;
                        $display("%0t is_last expected %0d actual %0d", $time,
                                 e.last, m_is_last);
                    end
                    if (e.status !== m_status) begin
                        fail_count++;
                        $display("%0t status expected %0d actual %0d", $time,
                                 e.status, m_status);
                    end
                end
            end
            if (s_valid && s_ready)
                merge_q = {merge_q, merge_step(s_operation, s_list_index, s_value)};
        end
        pending = merge_q.size();
    end
endmodule

### sim/testbench.sv
// top of the k-way merge testbench: clock, reset, apb writes, item stimulus, verdict
// depends on kwm_pkg, kwm_checker and k_way_sorted_merge_top
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import kwm_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [1:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_operation = 0;
    logic [2:0]  s_list_index = 0;
    logic [31:0] s_value = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [31:0] m_merged_value;
    logic        m_is_last;
    logic [1:0]  m_status;

    int fail_count, pending, results_seen;
    int send_idle = 0, recv_idle = 0;
    bit hold_recv = 0;
    int items_sent = 0, idle_cycles = 0;
    logic [3:0] cur_count = 4'd8;
    logic signed [31:0] ramp [8];

    k_way_sorted_merge_top dut (.*);

    kwm_scoreboard chk (
        .aclk, .aresetn,
        .cfg_we(psel && penable && pwrite && pready && paddr == 2'(CFG_LIST_COUNT * 4)),
        .cfg_count(pwdata[3:0]),
        .s_valid, .s_ready, .s_operation, .s_list_index, .s_value,
        .m_valid, .m_ready, .m_merged_value, .m_is_last, .m_status,
        .fail_count, .pending, .results_seen
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 0;
        else m_ready <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_count(input logic [3:0] n);
        @(posedge aclk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= 2'(CFG_LIST_COUNT * 4); pwdata <= 32'(n);
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        cur_count = n;
    endtask

    task automatic drain;
        s_valid <= 0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (2 * 8 + 10) @(posedge aclk);
    endtask

    task automatic send(input logic [1:0] op, input logic [2:0] li, input logic [31:0] v);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1; s_operation <= op; s_list_index <= li; s_value <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // sorted batch: non-decreasing values per list, then drain with takes
    task automatic sorted_batch(input int appends);
        int li;
        int takes;
        for (int i = 0; i < 8; i++) ramp[i] = $signed($urandom()) >>> $urandom_range(8, 31);
        send(OP_CLEAR, 0, $urandom());
        for (int i = 0; i < appends; i++) begin
            li = $urandom_range(cur_count == 0 ? 0 : (cur_count > 8 ? 7 : cur_count - 1));
            if ($urandom_range(9) == 0) li = $urandom_range(7);
            ramp[li] = ramp[li] + $urandom_range(3);
            send(OP_APPEND, 3'(li), ramp[li]);
        end
        takes = appends + $urandom_range(2);
        for (int i = 0; i < takes; i++) begin
            if ($urandom_range(19) == 0) send(OP_NONE, 3'($urandom()), $urandom());
            else send(OP_TAKE, 3'($urandom()), $urandom());
        end
    endtask

    initial begin
        int fills;
        repeat (10) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: extremes, equal heads, bad index, empty take, op 3
        send(OP_TAKE, 0, 0);
        send(OP_APPEND, 0, 32'h7fffffff);
        send(OP_APPEND, 1, 32'h80000000);
        send(OP_APPEND, 2, 32'h80000000);
        send(OP_APPEND, 7, 32'h5555aaaa);
        send(OP_APPEND, 3, 32'hffffffff);
        send(OP_TAKE, 7, 32'hffffffff);
        send(OP_TAKE, 0, 0);
        send(OP_TAKE, 0, 0);
        send(OP_TAKE, 0, 0);
        send(OP_TAKE, 0, 0);
        send(OP_TAKE, 0, 0);
        send(OP_NONE, 3'h7, 32'hffffffff);
        send(OP_APPEND, 4, 32'd0);
        send(OP_CLEAR, 0, 0);
        send(OP_TAKE, 0, 0);
        drain();

        write_count(4'd0);
        send(OP_APPEND, 0, 32'd1);
        send(OP_TAKE, 0, 0);
        drain();
        write_count(4'd15);
        send(OP_APPEND, 7, 32'd9);
        send(OP_TAKE, 0, 0);
        drain();
        write_count(4'd2);
        send(OP_APPEND, 2, 32'd5);
        send(OP_APPEND, 1, 32'd4);
        drain();
        write_count(4'd8);
        send(OP_TAKE, 0, 0);
        send(OP_TAKE, 0, 0);
        send(OP_CLEAR, 0, 0);
        drain();

        // fill one list to capacity then overflow
        write_count(4'd1);
        fills = 0;
        while (fills < 258) begin
            send(OP_APPEND, 0, 32'(fills));
            fills++;
        end
        send(OP_TAKE, 0, 0);
        send(OP_CLEAR, 0, 0);
        drain();

        // long receiver hold-off while items keep coming
        write_count(4'd8);
        hold_recv = 1;
        fork
            begin
                repeat (300) @(posedge aclk);
                hold_recv = 0;
            end
            for (int i = 0; i < 12; i++) send(OP_APPEND, 3'(i % 8), 32'(i));
        join
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 16 : (phase == 1 ? 73 : 0);
            recv_idle = (phase == 0) ? 73 : (phase == 1 ? 16 : 0);
            for (int b = 0; b < 4; b++) begin
                write_count(b == 0 ? 4'd8 : b == 1 ? 4'd1 : 4'($urandom_range(0, 15)));
                sorted_batch($urandom_range(6, 14));
                if (b == 2) drain();
                else if ($urandom_range(1)) begin
                    repeat (3) send(2'($urandom_range(3)), 3'($urandom()), $urandom());
                    drain();
                end else drain();
            end
        end
        send_idle = 0;
        recv_idle = 0;
        drain();

        $display("items sent %0d, results checked %0d, list counts 0 to 15, overflow and hold-off",
                 items_sent, results_seen);
        $display("three idling phases covered with sorted merges, appends and noise items");
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

### k_way_sorted_merge_top.f
+incdir+rtl
rtl/kwm_pkg.sv
rtl/kwm_ram.sv
rtl/kwm_front.sv
rtl/kwm_back.sv
rtl/k_way_sorted_merge_top.sv
rtl/kwm_checker.sv
sim/kwm_checker.sv
sim/testbench.sv
